@@ src/shps_pkg.sv @@
// ----------------------------------------------------------------------------
// shps_pkg: shared types and constants for the stepper homing sequencer
// Action codes, register indexes, coil table, state and result records.
// ----------------------------------------------------------------------------
`default_nettype none

package shps_pkg;

	// width of the tracked absolute position (8 to 32)
	localparam int PosBits    = 16;
	localparam int PosOutBits = 16;
	// signed compare width: holds the position and an unsigned 8-bit target
	localparam int CmpBits    = ((PosBits > 8) ? PosBits : 9) + 1;

	typedef enum logic [1:0] {
		ACT_TICK   = 2'd0,
		ACT_CW     = 2'd1,
		ACT_CCW    = 2'd2,
		ACT_TARGET = 2'd3
	} action_t;

	typedef enum logic {
		REG_HOMING_STEPS = 1'b0,
		REG_MAX_TARGET   = 1'b1
	} reg_index_t;

	localparam logic [7:0] HomingStepsReset = 8'd60;
	localparam logic [7:0] MaxTargetReset   = 8'd60;

	// full-step, two-phase-on drive sequence
	localparam logic [3:0] CoilTable [4] = '{4'hA, 4'h6, 4'h5, 4'h9};

	typedef struct packed {
		logic [1:0]         phase;
		logic [PosBits-1:0] pos;
		logic [7:0]         goal;
		logic [7:0]         homing_left;
		logic               homed;
	} shps_state_t;

	typedef struct packed {
		logic [3:0]            coil;
		logic                  stepped;
		logic                  step_dir;
		logic [PosOutBits-1:0] position;
		logic                  busy;
		logic                  rejected;
	} shps_result_t;

	// low output bits of the position, zero-filled when the position is narrower
	function automatic logic [PosOutBits-1:0] pos_out(input logic [PosBits-1:0] p);
		logic [PosBits+PosOutBits-1:0] w;
		w = {{PosOutBits{1'b0}}, p};
		return w[PosOutBits-1:0];
	endfunction

	function automatic logic signed [CmpBits-1:0] pos_cmp(input logic [PosBits-1:0] p);
		return signed'({{(CmpBits-PosBits){p[PosBits-1]}}, p});
	endfunction

	function automatic logic signed [CmpBits-1:0] goal_cmp(input logic [7:0] g);
		return signed'({{(CmpBits-8){1'b0}}, g});
	endfunction

endpackage

`default_nettype wire

@@ src/stepper_homing_position_sequencer_core.sv @@
// ----------------------------------------------------------------------------
// stepper_homing_position_sequencer_core: full-step stepper sequencer
// Manual steps, homing run and stepping toward a target, one result per item.
// ----------------------------------------------------------------------------
//  channel  | signals                              | direction
//  ---------+--------------------------------------+----------
//  input    | in_valid/in_ready, action, target    | in
//  result   | out_valid/out_ready, coil .. rejected| out
//  config   | cfg_wr_en, cfg_index, cfg_data       | in
//
//  One transaction per cycle when in_ready; result in the next cycle.
//  Position changes by at most one step or is zeroed by the step logic.
//  in_ready drops only while a result is held and out_ready is low.
//  arst_n clears the state, restores both registers and empties the result.
// ----------------------------------------------------------------------------
`default_nettype none

module stepper_homing_position_sequencer_core
	import shps_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         action,
	input  logic [7:0]         target_position,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [3:0]         coil_pattern,
	output logic               stepped,
	output logic               step_dir,
	output logic signed [15:0] position_now,
	output logic               busy_res,
	output logic               rejected,
	input  logic               cfg_wr_en,
	input  logic               cfg_index,
	input  logic [7:0]         cfg_data
);

	shps_state_t  state_q;
	shps_state_t  state_nxt;
	shps_result_t res_nxt;
	shps_result_t res_out;
	logic [7:0]   homing_steps_q;
	logic [7:0]   max_target_q;
	logic         accept;

	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			homing_steps_q <= HomingStepsReset;
			max_target_q   <= MaxTargetReset;
		end else if (cfg_wr_en) begin
			unique case (reg_index_t'(cfg_index))
				REG_HOMING_STEPS: homing_steps_q <= cfg_data;
				REG_MAX_TARGET:   max_target_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (accept) begin
			state_q <= state_nxt;
		end
	end

	shps_step_logic u_step (
		.cur             (state_q),
		.action          (action),
		.target_position (target_position),
		.homing_steps    (homing_steps_q),
		.max_target      (max_target_q),
		.nxt             (state_nxt),
		.res             (res_nxt)
	);

	shps_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept),
		.res_in    (res_nxt),
		.can_load  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res_out   (res_out)
	);

	assign coil_pattern = res_out.coil;
	assign stepped      = res_out.stepped;
	assign step_dir     = res_out.step_dir;
	assign position_now = signed'(res_out.position);
	assign busy_res     = res_out.busy;
	assign rejected     = res_out.rejected;

`ifndef NO_ASSERTIONS
	// no step means no coil drive and no direction
	a_idle_coils: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !stepped |-> coil_pattern == 4'h0 && !step_dir)
		else $error("coil pattern driven without a step");

	// a step always drives a legal two-phase-on pattern
	a_step_coils: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && stepped |-> coil_pattern == 4'hA || coil_pattern == 4'h6 ||
			coil_pattern == 4'h5 || coil_pattern == 4'h9)
		else $error("illegal coil pattern");

	// once homed the block never returns to the unhomed state
	a_homed_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.homed |=> state_q.homed)
		else $error("homed flag cleared");

	// a pending homing run only exists before homing completes
	a_homing_unhomed: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.homing_left != 8'd0 |-> !state_q.homed)
		else $error("homing steps left while homed");
`endif

endmodule

`default_nettype wire

@@ src/shps_step_logic.sv @@
// ----------------------------------------------------------------------------
// shps_step_logic: next-state and result logic for one transaction
// Decodes the action, takes at most one step and builds the result record.
// ----------------------------------------------------------------------------
`default_nettype none

module shps_step_logic
	import shps_pkg::*;
(
	input  shps_state_t  cur,
	input  logic [1:0]   action,
	input  logic [7:0]   target_position,
	input  logic [7:0]   homing_steps,
	input  logic [7:0]   max_target,
	output shps_state_t  nxt,
	output shps_result_t res
);

	action_t act;
	logic    do_step;
	logic    dir;
	logic    home_zero;
	logic    goal_gt;
	logic    goal_lt;

	assign act     = action_t'(action);
	assign goal_gt = goal_cmp(cur.goal) > pos_cmp(cur.pos);
	assign goal_lt = goal_cmp(cur.goal) < pos_cmp(cur.pos);

	always_comb begin
		nxt          = cur;
		res          = '0;
		do_step      = 1'b0;
		dir          = 1'b0;
		home_zero    = 1'b0;

		unique case (act)
			ACT_CW: begin
				do_step = 1'b1;
			end
			ACT_CCW: begin
				do_step = 1'b1;
				dir     = 1'b1;
			end
			ACT_TARGET: begin
				if (target_position > max_target) begin
					res.rejected = 1'b1;
				end else begin
					nxt.goal = target_position;
					// first accepted target after reset arms the homing run, or homes at once when homing_steps is zero
					if (!cur.homed && cur.homing_left == 8'd0) begin
						if (homing_steps == 8'd0) begin
							home_zero = 1'b1;
							nxt.homed = 1'b1;
						end else begin
							nxt.homing_left = homing_steps;
						end
					end
				end
			end
			ACT_TICK: begin
				if (!cur.homed) begin
					if (cur.homing_left != 8'd0) begin
						do_step         = 1'b1;
						dir             = 1'b1;
						nxt.homing_left = cur.homing_left - 8'd1;
						if (cur.homing_left == 8'd1) begin
							home_zero = 1'b1;
							nxt.homed = 1'b1;
						end
					end
				end else if (goal_gt) begin
					do_step = 1'b1;
				end else if (goal_lt) begin
					do_step = 1'b1;
					dir     = 1'b1;
				end
			end
			default: begin
			end
		endcase

		if (do_step) begin
			nxt.phase    = dir ? cur.phase - 2'd1 : cur.phase + 2'd1;
			nxt.pos      = dir ? cur.pos - 1'b1 : cur.pos + 1'b1;
			res.coil     = CoilTable[nxt.phase];
			res.stepped  = 1'b1;
			res.step_dir = dir;
		end
		if (home_zero) begin
			nxt.pos = '0;
		end

		res.position = pos_out(nxt.pos);
		if (!nxt.homed) begin
			res.busy = nxt.homing_left != 8'd0;
		end else begin
			res.busy = pos_cmp(nxt.pos) != goal_cmp(nxt.goal);
		end
	end

endmodule

`default_nettype wire

@@ src/shps_out_reg.sv @@
// ----------------------------------------------------------------------------
// shps_out_reg: result register
// Holds one result; takes a new one whenever it is empty or being drained.
// ----------------------------------------------------------------------------
`default_nettype none

module shps_out_reg
	import shps_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         load,
	input  shps_result_t res_in,
	output logic         can_load,
	output logic         out_valid,
	input  logic         out_ready,
	output shps_result_t res_out
);

	logic         valid_q;
	shps_result_t res_q;

	assign can_load  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign res_out   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_in;
		end
	end

endmodule

`default_nettype wire
